// ===== rtl/core/vawc_pkg.sv =====
package vawc_pkg;

    localparam int VOICE_COUNT_DEF      = 16;
    localparam int INSTRUMENT_COUNT_DEF = 16;

    localparam int LAYER_STEP = 21;
    localparam int LAYER_MAX  = 5;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_ADVANCE  = 2'd1;
    localparam logic [1:0] OP_FINISHED = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  instrument;
        logic [6:0]  velocity;
        logic [15:0] sample_count;
        logic [3:0]  finished_voice;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  voice_index;
        logic [3:0]  out_instrument;
        logic [2:0]  layer;
        logic [1:0]  round_robin;
        logic [6:0]  out_velocity;
        logic [31:0] start_stamp;
        logic        was_stolen;
    } t_out_item;

    // Velocity layer: (velocity - 1) / 21 capped at five, zero for velocity zero.
    function automatic logic [2:0] layer_of(input logic [6:0] vel);
        logic [2:0] l;
        l = 3'd0;
        for (int k = 1; k <= LAYER_MAX; k++) begin
            if (vel >= 7'(k * LAYER_STEP + 1)) begin
                l = 3'(k);
            end
        end
        return l;
    endfunction

endpackage

// ===== rtl/core/voice_allocator_with_choke_top.sv =====
// Voice allocator with per-instrument choke and oldest-voice steal. An advance
// or finished transfer is handled in the cycle it is accepted. A note on runs
// through acceptance, one pass over the voice table with an extra step for the
// registered memory read, and a commit step; the pass is the single scan that
// reads one voice per cycle and runs it through one shared compare unit. The
// commit step waits while the previous result still sits unread in the output
// register. The input side is stalled for the whole note-on sequence.
module voice_allocator_with_choke_top #(
    parameter int VOICE_COUNT      = vawc_pkg::VOICE_COUNT_DEF,
    parameter int INSTRUMENT_COUNT = vawc_pkg::INSTRUMENT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vawc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vawc_pkg::t_out_item o_out_data
);
    import vawc_pkg::*;

    localparam int IW  = $clog2(VOICE_COUNT);
    localparam int CW  = $clog2(VOICE_COUNT + 1);
    localparam int IAW = $clog2(INSTRUMENT_COUNT);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]                  r_state;
    logic [VOICE_COUNT-1:0]      r_active;
    logic [INSTRUMENT_COUNT-1:0] r_rr_vld;
    logic [31:0]                 r_sample_clock;
    logic                        r_out_vld;
    logic [CW-1:0]               r_cnt;
    logic                        r_found_free;

    t_in_item    r_item;
    t_out_item   r_out;
    logic [IW-1:0] r_free_idx;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_start;

    logic [3:0]  m_inst  [VOICE_COUNT];
    logic [31:0] m_start [VOICE_COUNT];
    logic [1:0]  m_rr    [INSTRUMENT_COUNT];
    logic [3:0]  r_inst_q;
    logic [31:0] r_start_q;
    logic [1:0]  r_rr_q;

    logic          in_fire;
    logic          inst_ok;
    logic          fin_ok;
    logic          commit_fire;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] chk_idx;
    logic          inst_match;
    logic          chk_free;
    logic [IW-1:0] pick;
    logic [IAW-1:0] rr_addr;
    logic [1:0]    rr_cur;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign inst_ok     = (32'(i_in_data.instrument) < INSTRUMENT_COUNT);
    assign fin_ok      = (32'(i_in_data.finished_voice) < VOICE_COUNT);
    assign commit_fire = (r_state == ST_COMMIT) && (!r_out_vld || !i_out_stall);
    assign rd_addr     = r_cnt[IW-1:0];
    assign chk_idx     = IW'(r_cnt - 1'b1);
    assign inst_match  = (r_inst_q == r_item.instrument);
    assign chk_free    = !r_active[chk_idx] || inst_match;
    assign pick        = r_found_free ? r_free_idx : r_best_idx;
    assign rr_addr     = IAW'(r_item.instrument);
    assign rr_cur      = r_rr_vld[rr_addr] ? r_rr_q : 2'd0;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_active       <= '0;
            r_rr_vld       <= '0;
            r_sample_clock <= '0;
            r_out_vld      <= 1'b0;
            r_cnt          <= '0;
            r_found_free   <= 1'b0;
        end else begin
            if (commit_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_cnt        <= '0;
                        r_found_free <= 1'b0;
                        case (i_in_data.opcode)
                            OP_NOTE_ON: begin
                                if (inst_ok) begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            OP_ADVANCE: begin
                                r_sample_clock <= r_sample_clock + 32'(i_in_data.sample_count);
                            end
                            OP_FINISHED: begin
                                if (fin_ok) begin
                                    r_active[IW'(i_in_data.finished_voice)] <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0) begin
                        if (r_active[chk_idx] && inst_match) begin
                            r_active[chk_idx] <= 1'b0;
                        end
                        if (!r_found_free && chk_free) begin
                            r_found_free <= 1'b1;
                        end
                    end
                    if (r_cnt == CW'(VOICE_COUNT)) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (commit_fire) begin
                        r_active[pick]    <= 1'b1;
                        r_rr_vld[rr_addr] <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_SCAN && r_cnt != '0) begin
            if (!r_found_free && chk_free) begin
                r_free_idx <= chk_idx;
            end
            if (chk_idx == '0 || r_start_q < r_best_start) begin
                r_best_idx   <= chk_idx;
                r_best_start <= r_start_q;
            end
        end
        if (commit_fire) begin
            r_out.voice_index    <= 4'(pick);
            r_out.out_instrument <= r_item.instrument;
            r_out.layer          <= layer_of(r_item.velocity);
            r_out.round_robin    <= rr_cur;
            r_out.out_velocity   <= r_item.velocity;
            r_out.start_stamp    <= r_sample_clock;
            r_out.was_stolen     <= !r_found_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_cnt < CW'(VOICE_COUNT)) begin
            r_inst_q  <= m_inst[rd_addr];
            r_start_q <= m_start[rd_addr];
        end
        if (in_fire && inst_ok) begin
            r_rr_q <= m_rr[IAW'(i_in_data.instrument)];
        end
        if (commit_fire) begin
            m_inst[pick]    <= r_item.instrument;
            m_start[pick]   <= r_sample_clock;
            m_rr[rr_addr]   <= rr_cur + 2'd1;
        end
    end

endmodule
